/* rtl/nlr_pkg.sv */
// Shared types and character constants for the number literal recognizer.
// No dependencies; imported by nlr_step, number_literal_recognizer and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package nlr_pkg;

    localparam logic [7:0]  C_DOT       = 8'h2E;
    localparam logic [7:0]  C_PLUS      = 8'h2B;
    localparam logic [7:0]  C_MINUS     = 8'h2D;
    localparam logic [7:0]  C_LOWER_E   = 8'h65;
    localparam logic [7:0]  C_UPPER_E   = 8'h45;
    localparam logic [7:0]  C_ZERO      = 8'h30;
    localparam logic [7:0]  C_NINE      = 8'h39;
    localparam logic [15:0] C_COUNT_MAX = 16'hFFFF;

    // Scanner state carried from one character to the next.
    typedef struct packed {
        logic [7:0]  pend_char;
        logic        pend_valid;
        logic [7:0]  bef_char;
        logic        bef_valid;
        logic        scanning;
        logic [15:0] count;
        logic        point;
        logic        expo;
    } t_state;

    // One input character with its framing flags.
    typedef struct packed {
        logic [7:0] ch;
        logic       begin_number;
        logic       text_first;
        logic       text_last;
    } t_item;

    // Result of one step; have is set when a scan ended.
    typedef struct packed {
        logic        have;
        logic [15:0] length;
        logic        malformed;
        logic        point;
        logic        expo;
    } t_result;

endpackage

`default_nettype wire

/* rtl/nlr_step.sv */
// Next-state and result logic of the scanner for one character.
// Depends on nlr_pkg for the state, item and result types.
`timescale 1ns / 1ps
`default_nettype none

module nlr_step
    import nlr_pkg::*;
(
    input  t_state  i_state,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    typedef struct packed {
        t_state  s;
        t_result r;
    } t_work;

    function automatic logic f_digit(input logic [7:0] c);
        f_digit = (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    function automatic logic f_sign(input logic [7:0] c);
        f_sign = (c == C_PLUS) || (c == C_MINUS);
    endfunction

    function automatic logic f_is_e(input logic [7:0] c);
        f_is_e = (c == C_LOWER_E) || (c == C_UPPER_E);
    endfunction

    function automatic t_work f_bump(input t_work w);
        t_work v;
        v = w;
        if (v.s.count != C_COUNT_MAX) begin
            v.s.count = v.s.count + 16'd1;
        end
        f_bump = v;
    endfunction

    // Only the first ending in a step reports; later ones just close the scan.
    function automatic t_work f_emit(input t_work w, input logic err);
        t_work v;
        v = w;
        if (!v.r.have) begin
            v.r.have      = 1'b1;
            v.r.length    = err ? 16'd0 : v.s.count;
            v.r.malformed = err;
            v.r.point     = !err && v.s.point;
            v.r.expo      = !err && v.s.expo;
        end
        v.s.scanning   = 1'b0;
        v.s.pend_valid = 1'b0;
        f_emit = v;
    endfunction

    function automatic t_work f_stop(input t_work w, input logic [7:0] c);
        f_stop = f_emit(w, (c != C_DOT) && (w.s.count == 16'd0));
    endfunction

    function automatic t_work f_resolve(input t_work w, input logic has_next,
                                        input logic [7:0] nx);
        t_work      v;
        logic [7:0] p;
        logic       ok;
        v = w;
        p = w.s.pend_char;
        if (f_is_e(p)) begin
            ok = has_next && (f_digit(nx) || f_sign(nx));
        end else begin
            ok = has_next && f_digit(nx);
        end
        v.s.pend_valid = 1'b0;
        if (ok) begin
            if (p == C_DOT) begin
                v.s.point = 1'b1;
            end else if (f_is_e(p)) begin
                v.s.expo = 1'b1;
            end
            v = f_bump(v);
        end else begin
            v = f_stop(v, p);
        end
        f_resolve = v;
    endfunction

    // A dot, an e or a sign that may continue the number waits for its successor.
    function automatic t_work f_examine(input t_work w, input logic [7:0] c,
                                        input logic last);
        t_work v;
        logic  hold;
        logic  after_e;
        v       = w;
        hold    = 1'b0;
        after_e = w.s.expo && w.s.bef_valid && f_is_e(w.s.bef_char);
        if (f_digit(c)) begin
            v = f_bump(v);
        end else if (c == C_DOT) begin
            if (w.s.point || last) begin
                v = f_stop(v, c);
            end else begin
                hold = 1'b1;
            end
        end else if (f_is_e(c)) begin
            if (w.s.expo || !w.s.bef_valid || !f_digit(w.s.bef_char) || last) begin
                v = f_stop(v, c);
            end else begin
                hold = 1'b1;
            end
        end else if (f_sign(c)) begin
            if (!((w.s.count == 16'd0) || after_e) || last) begin
                v = f_stop(v, c);
            end else begin
                hold = 1'b1;
            end
        end else begin
            v = f_stop(v, c);
        end
        if (hold) begin
            v.s.pend_char  = c;
            v.s.pend_valid = 1'b1;
        end
        f_examine = v;
    endfunction

    always_comb begin
        t_work w;
        w.s = i_state;
        w.r = '0;

        if (i_item.text_first) begin
            if (w.s.scanning) begin
                if (w.s.pend_valid) begin
                    w = f_resolve(w, 1'b0, 8'd0);
                end
                if (w.s.scanning) begin
                    w = f_emit(w, 1'b0);
                end
            end
            w.s.bef_valid = 1'b0;
        end else if (w.s.scanning && w.s.pend_valid) begin
            w = f_resolve(w, 1'b1, i_item.ch);
        end

        if (i_item.begin_number) begin
            if (w.s.scanning) begin
                w = f_emit(w, 1'b0);
            end
            w.s.scanning   = 1'b1;
            w.s.pend_valid = 1'b0;
            w.s.count      = 16'd0;
            w.s.point      = 1'b0;
            w.s.expo       = 1'b0;
        end

        if (w.s.scanning) begin
            w = f_examine(w, i_item.ch, i_item.text_last);
        end

        w.s.bef_char  = i_item.ch;
        w.s.bef_valid = 1'b1;

        if (i_item.text_last && w.s.scanning) begin
            w = f_emit(w, 1'b0);
        end

        o_state  = w.s;
        o_result = w.r;
    end

endmodule

`default_nettype wire

/* rtl/number_literal_recognizer.sv */
// Top level of the number literal recognizer: input register, scanner state, result register.
// Depends on nlr_pkg and nlr_step.
`timescale 1ns / 1ps
`default_nettype none

// The recognizer takes one character per clock cycle while o_stall is low and
// reports one result transaction when a number scan ends (length, dot and
// exponent flags, malformed flag); if two scans end on one character, only the
// first reports. A character is captured in an input register, judged by the
// scanner logic against the held state once the result register can take a
// result, and any result is loaded into the output register at the end of that
// cycle, which raises o_valid. The sustained rate is one character per cycle
// while the output is not stalled. While a result waits under i_stall, the next
// character is held in the input register and o_stall rises once that register is full.
module number_literal_recognizer
    import nlr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_begin_number,
    input  wire logic        i_text_first,
    input  wire logic        i_text_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_token_length,
    output logic             o_malformed,
    output logic             o_saw_point,
    output logic             o_saw_exponent
);

    t_state  r_state;
    t_state  n_state;
    t_item   r_in;
    logic    r_in_vld;
    logic    r_out_vld;
    t_result r_out;
    t_result w_res;
    logic    w_fire;

    nlr_step u_step (
        .i_state  (r_state),
        .i_item   (r_in),
        .o_state  (n_state),
        .o_result (w_res)
    );

    // The held character is processed whenever the result register can take a result.
    assign w_fire  = r_in_vld && !(r_out_vld && i_stall);
    assign o_stall = r_in_vld && !w_fire;

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in.ch           <= i_ch;
            r_in.begin_number <= i_begin_number;
            r_in.text_first   <= i_text_first;
            r_in.text_last    <= i_text_last;
        end
        if (w_fire && w_res.have) begin
            r_out <= w_res;
        end
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                r_in_vld <= 1'b1;
            end else if (w_fire) begin
                r_in_vld <= 1'b0;
            end
            if (w_fire && w_res.have) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
            if (w_fire) begin
                r_state <= n_state;
            end
        end
    end

    assign o_valid        = r_out_vld;
    assign o_token_length = r_out.length;
    assign o_malformed    = r_out.malformed;
    assign o_saw_point    = r_out.point;
    assign o_saw_exponent = r_out.expo;

    a_malformed_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_malformed |-> (o_token_length == 16'd0) && !o_saw_point
                                   && !o_saw_exponent)
        else $error("malformed result carries length or flags");

    a_pend_in_scan : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pend_valid |-> r_state.scanning)
        else $error("held character outside a scan");

    a_flags_need_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.scanning && (r_state.count == 16'd0) |-> !r_state.point && !r_state.expo)
        else $error("dot or exponent flag with empty count");

    a_hold_when_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && r_out_vld && i_stall |=> $stable(r_state))
        else $error("scanner state moved while the result was stalled");

    // The digit before an e may lie outside the scan, so one character is the floor.
    a_exponent_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saw_exponent |-> (o_token_length >= 16'd1))
        else $error("exponent reported on an empty number");

endmodule

`default_nettype wire

/* tb/sv/number_literal_recognizer_checker.sv */
// Checker for the number literal recognizer: watches both channels, predicts
// the token results from the accepted characters and compares them in order.
// Depends on nlr_pkg for the character constants and the item and result types.
`timescale 1ns / 1ps

module number_literal_recognizer_checker
    import nlr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_begin_number,
    input  wire logic        i_text_first,
    input  wire logic        i_text_last,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_token_length,
    input  wire logic        i_malformed,
    input  wire logic        i_saw_point,
    input  wire logic        i_saw_exponent,
    output int               o_errors,
    output int               o_waiting,
    output int               o_tokens
);

    // Scanner state as seen by the prediction.
    logic [7:0]  held_ch;
    logic        held_vld;
    logic [7:0]  prev_ch;
    logic        prev_vld;
    logic        in_scan;
    logic [15:0] char_count;
    logic        seen_point;
    logic        seen_expo;

    logic        got_tok;
    t_result     tok;
    t_result     expected_tokens[$];

    int errors = 0;
    int queued = 0;
    int tokens = 0;

    assign o_errors  = errors;
    assign o_waiting = queued;
    assign o_tokens  = tokens;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= C_ZERO && c <= C_NINE;
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return c == C_PLUS || c == C_MINUS;
    endfunction

    function automatic logic is_e(input logic [7:0] c);
        return c == C_LOWER_E || c == C_UPPER_E;
    endfunction

    // Only the first scan that ends within one transaction produces a token.
    task automatic close_scan(input logic err);
        if (!got_tok) begin
            got_tok        = 1'b1;
            tok.have       = 1'b1;
            tok.length     = err ? 16'd0 : char_count;
            tok.malformed  = err;
            tok.point      = !err && seen_point;
            tok.expo       = !err && seen_expo;
        end
        in_scan  = 1'b0;
        held_vld = 1'b0;
    endtask

    task automatic stop_on(input logic [7:0] c);
        close_scan(c != C_DOT && char_count == 16'd0);
    endtask

    task automatic judge_held(input logic has_next, input logic [7:0] nx);
        logic ok;
        if (is_e(held_ch)) begin
            ok = has_next && (is_digit(nx) || is_sign(nx));
        end else begin
            ok = has_next && is_digit(nx);
        end
        held_vld = 1'b0;
        if (ok) begin
            if (held_ch == C_DOT) begin
                seen_point = 1'b1;
            end else if (is_e(held_ch)) begin
                seen_expo = 1'b1;
            end
            if (char_count != C_COUNT_MAX) char_count = char_count + 16'd1;
        end else begin
            stop_on(held_ch);
        end
    endtask

    task automatic take_char(input logic [7:0] c, input logic last);
        logic keep;
        keep = 1'b0;
        if (is_digit(c)) begin
            if (char_count != C_COUNT_MAX) char_count = char_count + 16'd1;
        end else if (c == C_DOT) begin
            if (seen_point || last) stop_on(c);
            else keep = 1'b1;
        end else if (is_e(c)) begin
            if (seen_expo || !prev_vld || !is_digit(prev_ch) || last) stop_on(c);
            else keep = 1'b1;
        end else if (is_sign(c)) begin
            if (!(char_count == 16'd0 || (seen_expo && prev_vld && is_e(prev_ch))) || last)
                stop_on(c);
            else
                keep = 1'b1;
        end else begin
            stop_on(c);
        end
        if (keep) begin
            held_ch  = c;
            held_vld = 1'b1;
        end
    endtask

    task automatic scan_char(input t_item it);
        got_tok = 1'b0;
        if (it.text_first) begin
            // A new text closes the running scan; a held character has no successor.
            if (in_scan) begin
                if (held_vld) judge_held(1'b0, 8'h00);
                if (in_scan) close_scan(1'b0);
            end
            prev_vld = 1'b0;
        end else if (in_scan && held_vld) begin
            judge_held(1'b1, it.ch);
        end
        if (it.begin_number) begin
            if (in_scan) close_scan(1'b0);
            in_scan    = 1'b1;
            held_vld   = 1'b0;
            char_count = 16'd0;
            seen_point = 1'b0;
            seen_expo  = 1'b0;
        end
        if (in_scan) take_char(it.ch, it.text_last);
        prev_ch  = it.ch;
        prev_vld = 1'b1;
        if (it.text_last && in_scan) close_scan(1'b0);
        if (got_tok) expected_tokens.push_back(tok);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        if (!i_rst_n) begin
            held_ch    = 8'h00;
            held_vld   = 1'b0;
            prev_ch    = 8'h00;
            prev_vld   = 1'b0;
            in_scan    = 1'b0;
            char_count = 16'd0;
            seen_point = 1'b0;
            seen_expo  = 1'b0;
            expected_tokens.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                it.ch           = i_ch;
                it.begin_number = i_begin_number;
                it.text_first   = i_text_first;
                it.text_last    = i_text_last;
                scan_char(it);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_tokens.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected token, expected none, actual len=%0d mal=%0b pt=%0b exp=%0b",
                             $time, i_token_length, i_malformed, i_saw_point, i_saw_exponent);
                end else begin
                    want = expected_tokens.pop_front();
                    check_field("token_length", want.length, i_token_length);
                    check_field("malformed", want.malformed, i_malformed);
                    check_field("saw_point", want.point, i_saw_point);
                    check_field("saw_exponent", want.expo, i_saw_exponent);
                    tokens++;
                end
            end
        end
        queued = expected_tokens.size();
    end

endmodule

/* tb/sv/number_literal_recognizer_tb.sv */
// Testbench top for the number literal recognizer: clock, reset, character
// stimulus with random gaps and output stalls, watchdog and verdict.
// Depends on nlr_pkg, number_literal_recognizer and number_literal_recognizer_checker.
`timescale 1ns / 1ps

module number_literal_recognizer_tb;
    import nlr_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_ch = 8'h00;
    logic        i_begin_number = 1'b0;
    logic        i_text_first = 1'b0;
    logic        i_text_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_token_length;
    logic        o_malformed;
    logic        o_saw_point;
    logic        o_saw_exponent;

    int errors;
    int waiting;
    int tokens;

    int    sent_chars = 0;
    int    idle_cycles = 0;
    bit    calm = 1'b0;
    t_item line_buf[$];

    always #4 i_clk = ~i_clk;

    number_literal_recognizer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .i_begin_number (i_begin_number),
        .i_text_first   (i_text_first),
        .i_text_last    (i_text_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_length (o_token_length),
        .o_malformed    (o_malformed),
        .o_saw_point    (o_saw_point),
        .o_saw_exponent (o_saw_exponent)
    );

    number_literal_recognizer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_ch           (i_ch),
        .i_begin_number (i_begin_number),
        .i_text_first   (i_text_first),
        .i_text_last    (i_text_last),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_token_length (o_token_length),
        .i_malformed    (o_malformed),
        .i_saw_point    (o_saw_point),
        .i_saw_exponent (o_saw_exponent),
        .o_errors       (errors),
        .o_waiting      (waiting),
        .o_tokens       (tokens)
    );

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < 26);
    end

    // The watchdog only counts cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic add_char(input logic [7:0] c, input bit bn);
        t_item it;
        it.ch           = c;
        it.begin_number = bn;
        it.text_first   = 1'b0;
        it.text_last    = 1'b0;
        line_buf.push_back(it);
    endtask

    task automatic add_str(input string s, input bit bn);
        for (int k = 0; k < s.len(); k++) add_char(s[k], bn && k == 0);
    endtask

    task automatic add_digits(input int n);
        for (int k = 0; k < n; k++) add_char(C_ZERO + 8'($urandom_range(9)), 1'b0);
    endtask

    // Sends the buffered characters as one text; inputs change on the falling edge.
    task automatic send_line(input bit first, input bit last);
        if (line_buf.size() > 0) begin
            line_buf[0].text_first = first;
            line_buf[line_buf.size() - 1].text_last = last;
            foreach (line_buf[k]) begin
                while (!calm && $urandom_range(99) < 26) begin
                    i_valid <= 1'b0;
                    @(negedge i_clk);
                end
                i_valid        <= 1'b1;
                i_ch           <= line_buf[k].ch;
                i_begin_number <= line_buf[k].begin_number;
                i_text_first   <= line_buf[k].text_first;
                i_text_last    <= line_buf[k].text_last;
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                @(negedge i_clk);
                sent_chars++;
            end
            line_buf.delete();
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (waiting != 0) @(negedge i_clk);
    endtask

    // Mostly well-formed literals; a few miss digits or carry a stray byte.
    task automatic add_number();
        int start;
        start = line_buf.size();
        if ($urandom_range(99) < 30) add_char($urandom_range(1) ? C_PLUS : C_MINUS, 1'b1);
        if ($urandom_range(99) < 8) begin
            add_char(C_DOT, line_buf.size() == start);
            add_digits($urandom_range(1, 3));
        end else begin
            if (line_buf.size() == start) add_char(C_ZERO + 8'($urandom_range(9)), 1'b1);
            add_digits(($urandom_range(99) < 5) ? 0 : $urandom_range(0, 4));
            if ($urandom_range(99) < 35) begin
                add_char(C_DOT, 1'b0);
                add_digits(($urandom_range(99) < 8) ? 0 : $urandom_range(1, 4));
            end
            if ($urandom_range(99) < 30) begin
                add_char($urandom_range(1) ? C_LOWER_E : C_UPPER_E, 1'b0);
                if ($urandom_range(1)) add_char($urandom_range(1) ? C_PLUS : C_MINUS, 1'b0);
                add_digits(($urandom_range(99) < 8) ? 0 : $urandom_range(1, 3));
            end
        end
        if ($urandom_range(99) < 8) add_char(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic add_separator();
        case ($urandom_range(4))
            0: add_char(" ", 1'b0);
            1: add_char(",", 1'b0);
            2: add_char("x", 1'b0);
            3: add_char(")", 1'b0);
            default: add_char(8'($urandom_range(255)), $urandom_range(99) < 8);
        endcase
    endtask

    initial begin
        int lines;
        int words;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed texts: full literal, failures on the first character,
        // dot at the start and at the end, and the framing corner cases.
        add_str("+12.5e-3 ", 1'b1);  send_line(1'b1, 1'b1);
        add_str("x", 1'b1);          send_line(1'b1, 1'b1);
        add_str(".", 1'b1);          send_line(1'b1, 1'b1);
        add_str("1.2.", 1'b1);       send_line(1'b1, 1'b1);
        add_str("-+", 1'b1);         send_line(1'b1, 1'b1);
        // A begin inside a running scan closes it first.
        add_str("12", 1'b1);
        add_str("3", 1'b1);          send_line(1'b1, 1'b1);
        // A text start closes a scan whose held e has no successor.
        add_str("4e", 1'b1);         send_line(1'b1, 1'b0);
        add_char(8'h00, 1'b1);       send_line(1'b1, 1'b1);
        add_str("7E", 1'b1);
        add_char(8'hFF, 1'b0);       send_line(1'b1, 1'b1);
        // Two scans end on one character; only the earlier token is reported.
        add_str("9", 1'b1);          send_line(1'b1, 1'b0);
        add_str("8", 1'b1);          send_line(1'b0, 1'b1);
        // Without a text start, the previous text's last digit still precedes e.
        add_str("1", 1'b1);          send_line(1'b1, 1'b1);
        add_str("e", 1'b1);
        add_str("5 ", 1'b0);         send_line(1'b0, 1'b1);
        drain();

        lines = 0;
        while (sent_chars < 600) begin
            calm = (sent_chars >= 250 && sent_chars < 380);
            words = $urandom_range(1, 3);
            for (int w = 0; w < words; w++) begin
                if (w > 0 || $urandom_range(99) < 30) begin
                    add_separator();
                    if ($urandom_range(1)) add_separator();
                end
                add_number();
            end
            if ($urandom_range(1)) add_separator();
            send_line($urandom_range(19) != 0, $urandom_range(19) != 0);
            lines++;
            if (lines % 40 == 39) drain();
        end
        calm = 1'b0;

        drain();
        repeat (12) @(negedge i_clk);

        $display("Covered %0d characters and %0d checked tokens, with framing corner cases",
                 sent_chars, tokens);
        $display("and random gaps and stalls on both channels.");
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
